### hw/rtl/lprd_pkg.sv
// Shared types and codes for the length-prefixed record deframer.
`default_nettype none

package lprd_pkg;

    localparam int unsigned InDataWidth  = 40;
    localparam int unsigned OutDataWidth = 72;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_OVERRUN   = 2'd2,
        ST_TOO_SHORT = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_COUNT  = 5'b00010,
        PH_LEN    = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_IGNORE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [31:0] package_length;
        logic        first_of_package;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  record_byte;
        logic [31:0] record_index;
        logic [31:0] record_length;
        logic        last_of_record;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/lprd_in_reg.sv
// Input register stage that holds one accepted byte transfer for the parser.
`default_nettype none

module lprd_in_reg
    import lprd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [InDataWidth-1:0] s_tdata,  // data_byte, package_length
    input  wire logic                   s_tuser,  // first_of_package
    output logic                        item_valid,
    output item_t                       item,
    input  wire logic                   item_take
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte        <= s_tdata[7:0];
            item_reg.package_length   <= s_tdata[39:8];
            item_reg.first_of_package <= s_tuser;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lprd_core.sv
// Parser state and the combinational step that turns one byte into at most one result.
`default_nettype none

module lprd_core
    import lprd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire item_t item,
    output logic       emit,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] done_reg, done_next;
    logic [31:0] shift_reg, shift_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] bleft_reg, bleft_next;

    phase_t      eff_phase;
    logic [31:0] eff_left;
    logic [31:0] eff_total;
    logic [31:0] eff_done;
    logic [31:0] eff_shift;
    logic [1:0]  eff_cnt;
    logic [31:0] eff_bleft;
    logic [31:0] shifted;
    logic [31:0] left_dec;
    logic [31:0] done_inc;

    always_comb
    begin
        eff_phase = phase_reg;
        eff_left  = left_reg;
        eff_total = total_reg;
        eff_done  = done_reg;
        eff_shift = shift_reg;
        eff_cnt   = cnt_reg;
        eff_bleft = bleft_reg;
        emit      = 1'b0;
        result    = '{status: ST_DATA, record_byte: 8'd0, record_index: 32'd0,
                      record_length: 32'd0, last_of_record: 1'b0};

        if (item.first_of_package)
        begin
            eff_left  = item.package_length;
            eff_total = 32'd0;
            eff_done  = 32'd0;
            eff_shift = 32'd0;
            eff_cnt   = 2'd0;
            eff_bleft = 32'd0;
            if (item.package_length < 32'd4)
            begin
                eff_phase     = PH_IGNORE;
                emit          = 1'b1;
                result.status = ST_TOO_SHORT;
            end
            else
            begin
                eff_phase = PH_COUNT;
            end
        end

        shifted  = {eff_shift[23:0], item.data_byte};
        left_dec = eff_left - 32'd1;
        done_inc = eff_done + 32'd1;

        phase_next = eff_phase;
        left_next  = eff_left;
        total_next = eff_total;
        done_next  = eff_done;
        shift_next = eff_shift;
        cnt_next   = eff_cnt;
        bleft_next = eff_bleft;

        unique case (eff_phase)
            PH_COUNT:
            begin
                left_next = left_dec;
                if (eff_cnt == 2'd3)
                begin
                    total_next = shifted;
                    shift_next = 32'd0;
                    cnt_next   = 2'd0;
                    phase_next = (shifted == 32'd0) ? PH_IGNORE : PH_LEN;
                end
                else
                begin
                    shift_next = shifted;
                    cnt_next   = eff_cnt + 2'd1;
                end
            end
            PH_LEN:
            begin
                if (eff_cnt == 2'd0 && eff_left < 32'd4)
                begin
                    phase_next          = PH_IGNORE;
                    emit                = 1'b1;
                    result.status       = ST_OVERRUN;
                    result.record_index = eff_done;
                end
                else
                begin
                    left_next  = left_dec;
                    shift_next = shifted;
                    if (eff_cnt != 2'd3)
                    begin
                        cnt_next = eff_cnt + 2'd1;
                    end
                    else
                    begin
                        cnt_next = 2'd0;
                        if (shifted > left_dec)
                        begin
                            phase_next           = PH_IGNORE;
                            emit                 = 1'b1;
                            result.status        = ST_OVERRUN;
                            result.record_index  = eff_done;
                            result.record_length = shifted;
                        end
                        else if (shifted == 32'd0)
                        begin
                            done_next             = done_inc;
                            shift_next            = 32'd0;
                            phase_next = (done_inc == eff_total) ? PH_IGNORE : PH_LEN;
                            emit                  = 1'b1;
                            result.status         = ST_EMPTY;
                            result.record_index   = eff_done;
                            result.last_of_record = 1'b1;
                        end
                        else
                        begin
                            bleft_next = shifted;
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                emit                  = 1'b1;
                result.status         = ST_DATA;
                result.record_byte    = item.data_byte;
                result.record_index   = eff_done;
                result.record_length  = eff_shift;
                result.last_of_record = (eff_bleft == 32'd1);
                left_next             = left_dec;
                bleft_next            = eff_bleft - 32'd1;
                if (eff_bleft == 32'd1)
                begin
                    done_next  = done_inc;
                    cnt_next   = 2'd0;
                    shift_next = 32'd0;
                    phase_next = (done_inc == eff_total) ? PH_IGNORE : PH_LEN;
                end
            end
            PH_IDLE, PH_IGNORE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= 32'd0;
            total_reg <= 32'd0;
            done_reg  <= 32'd0;
            shift_reg <= 32'd0;
            cnt_reg   <= 2'd0;
            bleft_reg <= 32'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
            bleft_reg <= bleft_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lprd_out_reg.sv
// Result register that presents one record transfer on the output stream.
`default_nettype none

module lprd_out_reg
    import lprd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_valid,
    input  wire logic                    emit,
    input  wire result_t                 result,
    output logic                         advance,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OutDataWidth-1:0]      m_tdata,  // record_byte, record_index, record_length
    output logic [1:0]                   m_tuser,  // status
    output logic                         m_tlast   // last_of_record
);

    logic    valid_reg;
    result_t res_reg;

    assign advance  = item_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.record_length, res_reg.record_index, res_reg.record_byte};
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last_of_record;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= emit;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_reg <= result;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/length_prefixed_record_deframer.sv
// Top level of the length-prefixed record deframer.
//
// The block takes a package one byte per transfer and splits it into records: a 4-byte
// big-endian record count, then per record a 4-byte big-endian length and that many data
// bytes. It sustains one byte per clock cycle in both directions unless m_tready holds the
// output; a byte goes from the input register through the combinational parse step into the
// result register, which presents it. A byte yields at most one output transfer; count bytes
// other than the first of a too-short package, length bytes that end no empty record and find
// no overrun, bytes after the last record and later bytes of a rejected package yield none.
`default_nettype none

module length_prefixed_record_deframer
    import lprd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [InDataWidth-1:0]  s_tdata,  // data_byte, package_length
    input  wire logic                    s_tuser,  // first_of_package
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OutDataWidth-1:0]      m_tdata,  // record_byte, record_index, record_length
    output logic [1:0]                   m_tuser,  // status
    output logic                         m_tlast   // last_of_record
);

    logic    item_valid;
    item_t   item;
    logic    advance;
    logic    emit;
    result_t result;

    lprd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (advance)
    );

    lprd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .emit    (emit),
        .result  (result)
    );

    lprd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .emit       (emit),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
